// ----- src/dutc_pkg.sv -----
`default_nettype none
package dutc_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam logic [15:0] MIN_PAYLOAD = 16'd16;
	localparam logic [15:0] QUERY_MASK = 16'hFA00;
	localparam logic [15:0] RESP_MASK = 16'hF800;
	localparam logic [15:0] RESP_VALUE = 16'h8000;
	localparam logic [15:0] DEFAULT_INTERVAL = 16'd30;

	localparam logic [1:0] CMD_OUTGOING = 2'd0;
	localparam logic [1:0] CMD_INCOMING = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;
	localparam logic [1:0] CMD_RESERVED = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic [31:0] key_ip;
		logic [15:0] key_port;
		logic [31:0] dest_ip;
		logic [15:0] dest_port;
	} entry_t;

	typedef struct packed {
		logic        sweep;
		logic [31:0] sweep_time;
		logic [15:0] interval;
		logic        insert;
		logic        remove;
		entry_t      data;
		logic [31:0] stamp;
	} cell_op_t;

endpackage
`default_nettype wire

// ----- src/dutc_cell.sv -----
`default_nettype none
module dutc_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dutc_pkg::cell_op_t op,
	input  wire logic              take_in,
	output logic                   take_out,
	output logic                   hit,
	output dutc_pkg::entry_t       hit_data
);
	import dutc_pkg::*;

	logic        valid_q;
	entry_t      ent_q;
	logic [31:0] stamp_q;
	logic [31:0] age;
	logic        free;
	logic        grab;

	always_comb begin
		free = !valid_q;
		hit = valid_q && (ent_q.key_ip == op.data.key_ip) && (ent_q.key_port == op.data.key_port);
		take_out = take_in && !free;
		grab = op.insert && take_in && free;
		age = op.sweep_time - stamp_q;
		hit_data = hit ? ent_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.sweep && valid_q && (age >= {16'd0, op.interval})) begin
			valid_q <= 1'b0;
		end else if (op.remove && hit) begin
			valid_q <= 1'b0;
		end else if (grab) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (grab) begin
			ent_q <= op.data;
			stamp_q <= op.stamp;
		end
	end

endmodule
`default_nettype wire

// ----- src/dns_udp_conntrack_table_core.sv -----
// DNS-over-UDP connection table: a row of 64 entry cells that each compare the packet key and
// age themselves, with a free-slot token rippling from cell 0 upward so the lowest free entry
// takes an insert. Each item goes through accept, aging sweep, and lookup and update, and the last
// of these waits while the result register is still held by the consumer, before the next accept.
// One result item is returned for every input item, including ticks.
`default_nettype none
module dns_udp_conntrack_table_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [15:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// src_ip, src_port, dst_ip, dst_port, header_flags, answer_count, payload_length.
	input  wire logic [143:0] s_tdata,
	// command.
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// accepted, orig_src_ip, orig_src_port, orig_dst_ip, orig_dst_port, table_full, zero pad.
	output logic [103:0]      m_tdata
);
	import dutc_pkg::*;

	state_t      state_q, state_nxt;
	logic [1:0]  cmd_q;
	logic [31:0] sip_q, dip_q;
	logic [15:0] sport_q, dport_q, flags_q, ancount_q, plen_q;
	logic [31:0] now_q, last_q;
	logic        started_q;
	logic [15:0] interval_q;
	logic        out_valid_q;
	logic [103:0] out_q;
	logic [103:0] result;

	cell_op_t    op;
	logic [TABLE_ENTRIES:0] take;
	logic [TABLE_ENTRIES-1:0] hits;
	entry_t      hit_data [TABLE_ENTRIES];
	entry_t      found;
	logic        any_hit, pkt_ok, sweep_due, fire, query_ok, resp_ok, full, accepted;

	assign take[0] = 1'b1;

	genvar g;
	generate
		for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
			dutc_cell u_cell (
				.clk(clk), .arst_n(arst_n), .op(op),
				.take_in(take[g]), .take_out(take[g+1]),
				.hit(hits[g]), .hit_data(hit_data[g])
			);
		end
	endgenerate

	always_comb begin
		found = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			found = found | hit_data[i];
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_SWEEP;
			end
			ST_SWEEP: state_nxt = ST_APPLY;
			ST_APPLY: begin
				if (fire) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		pkt_ok = ((cmd_q == CMD_OUTGOING) || (cmd_q == CMD_INCOMING)) && (plen_q >= MIN_PAYLOAD);
		sweep_due = started_q && ((now_q - last_q) >= {16'd0, interval_q});
		fire = (state_q == ST_APPLY) && (!out_valid_q || m_tready);
		any_hit = |hits;
		full = take[TABLE_ENTRIES];
		query_ok = (cmd_q == CMD_OUTGOING) && pkt_ok && ((flags_q & QUERY_MASK) == 16'd0)
			&& (ancount_q == 16'd0) && (sip_q != 32'd0) && (sport_q != 16'd0)
			&& (dip_q != 32'd0) && (dport_q != 16'd0);
		resp_ok = (cmd_q == CMD_INCOMING) && pkt_ok && ((flags_q & RESP_MASK) == RESP_VALUE);
		op.sweep = (state_q == ST_SWEEP) && pkt_ok && sweep_due;
		op.sweep_time = now_q;
		op.interval = interval_q;
		op.insert = fire && query_ok && !any_hit;
		op.remove = fire && resp_ok;
		op.data.key_ip = sip_q;
		op.data.key_port = sport_q;
		op.data.dest_ip = dip_q;
		op.data.dest_port = dport_q;
		op.stamp = now_q;
		accepted = (query_ok && !any_hit && !full) || (resp_ok && any_hit);
		result = '0;
		result[0] = accepted;
		if (resp_ok && any_hit) begin
			result[32:1] = found.key_ip;
			result[48:33] = found.key_port;
			result[80:49] = found.dest_ip;
			result[96:81] = found.dest_port;
		end
		result[97] = query_ok && !any_hit && full;
		m_tvalid = out_valid_q;
		m_tdata = out_q;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= s_tuser;
			sip_q <= s_tdata[31:0];
			sport_q <= s_tdata[47:32];
			dip_q <= s_tdata[79:48];
			dport_q <= s_tdata[95:80];
			flags_q <= s_tdata[111:96];
			ancount_q <= s_tdata[127:112];
			plen_q <= s_tdata[143:128];
		end
		if (fire) begin
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q <= '0;
			last_q <= '0;
			started_q <= 1'b0;
			interval_q <= DEFAULT_INTERVAL;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) interval_q <= cfg_wdata;
			if ((state_q == ST_SWEEP) && pkt_ok) begin
				if (!started_q) begin
					started_q <= 1'b1;
					last_q <= now_q;
				end else if (sweep_due) begin
					last_q <= now_q;
				end
			end
			if (fire && (cmd_q == CMD_TICK)) now_q <= now_q + 32'd1;
			if (fire) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dutc_pkg::*;

	localparam int NUM_RANDOM = 670;
	localparam longint CYCLE_LIMIT = 400000;

	class conntrack_scoreboard;
		logic [15:0] interval;
		logic        ent_valid [TABLE_ENTRIES];
		logic [31:0] ent_key_ip [TABLE_ENTRIES];
		logic [15:0] ent_key_port [TABLE_ENTRIES];
		logic [31:0] ent_dst_ip [TABLE_ENTRIES];
		logic [15:0] ent_dst_port [TABLE_ENTRIES];
		logic [31:0] ent_stamp [TABLE_ENTRIES];
		logic [31:0] now_sec;
		logic [31:0] last_sweep;
		logic        sweep_armed;
		logic [103:0] pending_results [$];
		int errors;

		function new();
			interval = DEFAULT_INTERVAL;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				ent_valid[i] = 1'b0;
			end
			now_sec = '0;
			last_sweep = '0;
			sweep_armed = 1'b0;
			errors = 0;
		endfunction

		function void age_out();
			if (!sweep_armed) begin
				sweep_armed = 1'b1;
				last_sweep = now_sec;
				return;
			end
			if (now_sec - last_sweep >= {16'd0, interval}) begin
				last_sweep = now_sec;
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (ent_valid[i] && (last_sweep - ent_stamp[i]) >= {16'd0, interval})
						ent_valid[i] = 1'b0;
				end
			end
		endfunction

		function int lookup(logic [31:0] ip, logic [15:0] port);
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (ent_valid[i] && ent_key_ip[i] == ip && ent_key_port[i] == port)
					return i;
			end
			return -1;
		endfunction

		function void note_item(logic [1:0] cmd, logic [143:0] d);
			logic [31:0] sip, dip;
			logic [15:0] sport, dport, flags, ancount, plen;
			logic accepted, full;
			logic [31:0] o_sip, o_dip;
			logic [15:0] o_sport, o_dport;
			int hit;
			{plen, ancount, flags, dport, dip, sport, sip} = d;
			accepted = 0; full = 0; o_sip = 0; o_dip = 0; o_sport = 0; o_dport = 0;
			if (cmd == CMD_TICK) begin
				now_sec = now_sec + 1;
			end else if (cmd != CMD_OUTGOING && cmd != CMD_INCOMING || plen < MIN_PAYLOAD) begin
			end else begin
				age_out();
				if (cmd == CMD_OUTGOING) begin
					if ((flags & QUERY_MASK) == 0 && ancount == 0 && sip != 0 && sport != 0
							&& dip != 0 && dport != 0 && lookup(sip, sport) < 0) begin
						full = 1'b1;
						for (int i = 0; i < TABLE_ENTRIES; i++) begin
							if (!ent_valid[i]) begin
								ent_valid[i] = 1'b1;
								ent_key_ip[i] = sip;
								ent_key_port[i] = sport;
								ent_dst_ip[i] = dip;
								ent_dst_port[i] = dport;
								ent_stamp[i] = now_sec;
								accepted = 1'b1;
								full = 1'b0;
								break;
							end
						end
					end
				end else if ((flags & RESP_MASK) == RESP_VALUE) begin
					hit = lookup(sip, sport);
					if (hit >= 0) begin
						accepted = 1'b1;
						o_sip = ent_key_ip[hit];
						o_sport = ent_key_port[hit];
						o_dip = ent_dst_ip[hit];
						o_dport = ent_dst_port[hit];
						ent_valid[hit] = 1'b0;
					end
				end
			end
			pending_results.push_back({6'd0, full, o_dport, o_dip, o_sport, o_sip, accepted});
		endfunction

		function void check_result(logic [103:0] got);
			logic [103:0] want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got[0] !== want[0]) begin
				$display("%0t: accepted expected %h actual %h", $time, want[0], got[0]);
				errors++;
			end
			if (got[32:1] !== want[32:1]) begin
				$display("%0t: orig_src_ip expected %h actual %h", $time, want[32:1], got[32:1]);
				errors++;
			end
			if (got[48:33] !== want[48:33]) begin
				$display("%0t: orig_src_port expected %h actual %h", $time, want[48:33],
					got[48:33]);
				errors++;
			end
			if (got[80:49] !== want[80:49]) begin
				$display("%0t: orig_dst_ip expected %h actual %h", $time, want[80:49],
					got[80:49]);
				errors++;
			end
			if (got[96:81] !== want[96:81]) begin
				$display("%0t: orig_dst_port expected %h actual %h", $time, want[96:81],
					got[96:81]);
				errors++;
			end
			if (got[103:97] !== want[103:97]) begin
				$display("%0t: table_full/pad expected %h actual %h", $time, want[103:97],
					got[103:97]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [143:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [103:0] m_tdata;

	conntrack_scoreboard tracker;
	longint cycle_count = 0;
	logic [31:0] known_ip [8];
	logic [15:0] known_port [8];

	dns_udp_conntrack_table_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata);
	end

	initial begin : consumer
		int stall;
		int quiet;
		wait (arst_n);
		forever begin
			@(negedge clk);
			quiet = $urandom_range(0, 199);
			stall = (quiet < 60) ? 0 : gap_length();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(logic [1:0] cmd, logic [31:0] sip, logic [15:0] sport,
			logic [31:0] dip, logic [15:0] dport, logic [15:0] flags,
			logic [15:0] ancount, logic [15:0] plen);
		@(negedge clk);
		s_tuser <= cmd;
		s_tdata <= {plen, ancount, flags, dport, dip, sport, sip};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_item(cmd, {plen, ancount, flags, dport, dip, sport, sip});
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic send_paced(logic [1:0] cmd, logic [31:0] sip, logic [15:0] sport,
			logic [31:0] dip, logic [15:0] dport, logic [15:0] flags,
			logic [15:0] ancount, logic [15:0] plen, bit paced);
		int g;
		g = paced ? gap_length() : 0;
		repeat (g) @(negedge clk);
		send_item(cmd, sip, sport, dip, dport, flags, ancount, plen);
	endtask

	task automatic drain();
		while (tracker.pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_interval(logic [15:0] value);
		drain();
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.interval = value;
	endtask

	task automatic random_phase(int count);
		int kind, k;
		bit paced;
		logic [15:0] flags, plen;
		for (int n = 0; n < count; n++) begin
			paced = (n % 100) >= 30;
			kind = $urandom_range(0, 99);
			k = $urandom_range(0, 7);
			plen = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 15))
				: 16'($urandom_range(16, 65535));
			if (kind < 40) begin
				flags = ($urandom_range(0, 9) == 0) ? 16'($urandom)
					: (16'($urandom) & ~QUERY_MASK);
				send_paced(CMD_OUTGOING, ($urandom_range(0, 30) == 0) ? 32'd0 : known_ip[k],
					($urandom_range(0, 30) == 0) ? 16'd0 : known_port[k],
					($urandom_range(0, 30) == 0) ? 32'd0 : $urandom,
					($urandom_range(0, 30) == 0) ? 16'd0 : 16'($urandom), flags,
					($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'd0, plen, paced);
			end else if (kind < 75) begin
				flags = ($urandom_range(0, 7) == 0) ? 16'($urandom)
					: ((16'($urandom) & ~RESP_MASK) | RESP_VALUE);
				send_paced(CMD_INCOMING, known_ip[k], known_port[k], $urandom,
					16'($urandom), flags, 16'($urandom), plen, paced);
			end else if (kind < 93) begin
				send_paced(CMD_TICK, $urandom, 16'($urandom), $urandom, 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom), paced);
			end else if (kind < 96) begin
				send_paced(CMD_RESERVED, $urandom, 16'($urandom), $urandom, 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom), paced);
			end else begin
				send_paced(CMD_OUTGOING, $urandom, 16'($urandom), $urandom, 16'($urandom),
					16'($urandom) & ~QUERY_MASK, 16'd0, 16'hFFFF, paced);
			end
		end
	endtask

	initial begin : stimulus
		tracker = new();
		for (int k = 0; k < 8; k++) begin
			known_ip[k] = $urandom | 32'h1;
			known_port[k] = 16'($urandom) | 16'h1;
		end
		known_ip[0] = 32'hFFFF_FFFF;
		known_port[0] = 16'hFFFF;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: first packet arms aging, short payload, bad query fields, duplicates.
		send_item(CMD_OUTGOING, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h0500,
			16'd0, 16'd16);
		send_item(CMD_OUTGOING, 32'h1, 16'h1, 32'h1, 16'h1, 16'h0, 16'd0, 16'd15);
		send_item(CMD_OUTGOING, 32'h0, 16'h5, 32'h7, 16'h9, 16'h0, 16'd0, 16'd100);
		send_item(CMD_OUTGOING, 32'h5, 16'h0, 32'h7, 16'h9, 16'h0, 16'd0, 16'd100);
		send_item(CMD_OUTGOING, 32'h5, 16'h5, 32'h0, 16'h9, 16'h0, 16'd0, 16'd100);
		send_item(CMD_OUTGOING, 32'h5, 16'h5, 32'h7, 16'h0, 16'h0, 16'd0, 16'd100);
		send_item(CMD_OUTGOING, 32'h5, 16'h5, 32'h7, 16'h9, QUERY_MASK, 16'd0, 16'd100);
		send_item(CMD_OUTGOING, 32'h5, 16'h5, 32'h7, 16'h9, 16'h0, 16'hFFFF, 16'd100);
		send_item(CMD_OUTGOING, 32'hFFFF_FFFF, 16'hFFFF, 32'h1, 16'h1, 16'h0, 16'd0, 16'd64);
		send_item(CMD_INCOMING, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 16'h7FFF, 16'd0, 16'd64);
		send_item(CMD_INCOMING, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 16'hFFFF, 16'd0, 16'hFFFF);
		send_item(CMD_INCOMING, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 16'h8000, 16'd0, 16'hFFFF);
		send_item(CMD_RESERVED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF);
		// Fill the table past its capacity.
		for (int i = 0; i < TABLE_ENTRIES + 2; i++)
			send_item(CMD_OUTGOING, 32'h100 + i, 16'h10, 32'hA, 16'h35, 16'h0100, 16'd0, 16'd32);
		// Aging with an interval of one.
		write_interval(16'd1);
		send_item(CMD_TICK, 32'h0, 16'h0, 32'h0, 16'h0, 16'h0, 16'd0, 16'd0);
		send_item(CMD_INCOMING, 32'h100, 16'h10, 32'h0, 16'h0, 16'h8000, 16'd0, 16'd32);
		send_item(CMD_INCOMING, 32'h101, 16'h10, 32'h0, 16'h0, 16'h8000, 16'd0, 16'd32);

		random_phase(150);
		write_interval(16'd0);
		random_phase(100);
		write_interval(16'hFFFF);
		random_phase(150);
		// Hold off until every result is back, then go on.
		drain();
		write_interval(16'd3);
		random_phase(180);
		write_interval(16'd30);
		random_phase(NUM_RANDOM - 580);

		drain();
		repeat (20) @(negedge clk);
		if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
